@@ sv/ectu_pkg.sv @@
// Shared types and constants for the edge cost table upsert block.
package ectu_pkg;

    // Fixed field widths
    localparam int NAME_W   = 8;
    localparam int COST_W   = 16;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int EDGE_W   = NAME_W + COST_W;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED   = 3'd0,
        ST_UNCHANGED = 3'd1,
        ST_ADDED     = 3'd2,
        ST_CREATED   = 3'd3,
        ST_DROPPED   = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_NSCAN,
        S_ELOAD,
        S_ESCAN
    } t_state;

endpackage

@@ sv/ectu_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
module ectu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/edge_cost_table_upsert.sv @@
// Top level of the edge cost table upsert block.
//
// Usage: present source, destination and cost with start high; the beat is taken
// at a rising edge where start is high and busy is low. Exactly one result beat
// follows per input: o_valid is high for one cycle with o_status and o_node_slot.
// The receiver cannot stall; results must be taken in the cycle they are shown.
//
// Sequence, from acceptance to the result: a pipelined walk of the node name
// memory (one slot read per cycle, up to the used slots), a fetch of the edge
// count, a walk of the edge memory (up to the held edges), and the registered
// result. A new node or a full node table ends after the node walk. Each memory
// has a single read port.
// One item is worked at a time; busy is high from acceptance to the decision, so
// the next beat can be taken in the cycle its predecessor's result is shown.
//
// Reset (synchronous, active low) clears the slot count and the sequencer; the
// memories need no clearing, as only used slots and held edges are ever read.
module edge_cost_table_upsert
    import ectu_pkg::*;
#(
    parameter int NODE_COUNT     = 16,
    parameter int EDGES_PER_NODE = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [NAME_W-1:0]   i_source_node,
    input  logic [NAME_W-1:0]   i_dest_node,
    input  logic [COST_W-1:0]   i_edge_cost,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_node_slot
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int UW = $clog2(NODE_COUNT + 1);
    localparam int CW = $clog2(EDGES_PER_NODE + 1);
    localparam int ED = NODE_COUNT * EDGES_PER_NODE;
    localparam int AW = $clog2(ED);
    localparam logic [UW-1:0] NODE_LIMIT = UW'(NODE_COUNT);
    localparam logic [CW-1:0] EDGES_MAX  = CW'(EDGES_PER_NODE);
    localparam logic [AW-1:0] EPN_A      = AW'(EDGES_PER_NODE);

    t_state r_state, n_state;

    logic [NAME_W-1:0]   r_src, r_dst;
    logic [COST_W-1:0]   r_cost;
    logic [UW-1:0]       r_used;
    logic [UW-1:0]       r_idx;
    logic                r_pend;
    logic [NW-1:0]       r_pidx;
    logic [NW-1:0]       r_slot;
    logic [AW-1:0]       r_base;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_eidx;
    logic [CW-1:0]       r_epidx;
    logic                r_valid;
    t_status             r_status;
    logic [SLOT_W-1:0]   r_node_slot;

    // Memory ports
    logic [NAME_W-1:0]   nm_rd;
    logic                nm_we;
    logic [CW-1:0]       cnt_rd;
    logic                cnt_we;
    logic [NW-1:0]       cnt_waddr;
    logic [CW-1:0]       cnt_wdata;
    logic [EDGE_W-1:0]   ed_rd;
    logic                ed_we;
    logic [AW-1:0]       ed_waddr;
    logic [AW-1:0]       ed_raddr;

    // Decision signals
    logic                accept;
    logic                node_hit, node_miss, node_issue;
    logic                edge_hit, edge_miss, edge_issue;
    logic                done;
    t_status             n_status;
    logic [SLOT_W-1:0]   n_node_slot;
    logic [AW-1:0]       new_base;

    assign accept   = start && (r_state == S_IDLE);
    assign busy     = (r_state != S_IDLE);
    assign new_base = AW'(AW'(r_used[NW-1:0]) * EPN_A);
    assign ed_raddr = r_base + AW'(r_eidx);

    // Scan compares against the read issued last cycle
    assign node_hit   = r_pend && (nm_rd == r_src);
    assign node_miss  = (r_idx == r_used) && !node_hit;
    assign node_issue = !node_hit && (r_idx != r_used);
    assign edge_hit   = r_pend && (ed_rd[EDGE_W-1:COST_W] == r_dst);
    assign edge_miss  = (r_eidx == r_cnt) && !edge_hit;
    assign edge_issue = !edge_hit && (r_eidx != r_cnt);

    // Node name store
    ectu_ram #(.WIDTH(NAME_W), .DEPTH(NODE_COUNT)) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (r_used[NW-1:0]),
        .i_wdata (r_src),
        .i_raddr (r_idx[NW-1:0]),
        .o_rdata (nm_rd)
    );

    // Edge count per node
    ectu_ram #(.WIDTH(CW), .DEPTH(NODE_COUNT)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_pidx),
        .o_rdata (cnt_rd)
    );

    // Edge entries: destination and cost
    ectu_ram #(.WIDTH(EDGE_W), .DEPTH(ED)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (ed_we),
        .i_waddr (ed_waddr),
        .i_wdata ({r_dst, r_cost}),
        .i_raddr (ed_raddr),
        .o_rdata (ed_rd)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_NSCAN;
                end
            end
            S_NSCAN: begin
                if (node_hit) begin
                    n_state = S_ELOAD;
                end else if (node_miss) begin
                    n_state = S_IDLE;
                end
            end
            S_ELOAD: begin
                n_state = S_ESCAN;
            end
            S_ESCAN: begin
                if (edge_hit || edge_miss) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory writes and result decision
    always_comb begin
        nm_we       = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = r_slot;
        cnt_wdata   = r_cnt + CW'(1);
        ed_we       = 1'b0;
        ed_waddr    = r_base + AW'(r_cnt);
        done        = 1'b0;
        n_status    = ST_DROPPED;
        n_node_slot = '0;
        case (r_state)
            S_NSCAN: begin
                if (node_miss) begin
                    done = 1'b1;
                    if (r_used != NODE_LIMIT) begin
                        nm_we       = 1'b1;
                        cnt_we      = 1'b1;
                        cnt_waddr   = r_used[NW-1:0];
                        cnt_wdata   = CW'(1);
                        ed_we       = 1'b1;
                        ed_waddr    = new_base;
                        n_status    = ST_CREATED;
                        n_node_slot = SLOT_W'(r_used);
                    end
                end
            end
            S_ESCAN: begin
                if (edge_hit) begin
                    done        = 1'b1;
                    n_node_slot = SLOT_W'(r_slot);
                    ed_waddr    = r_base + AW'(r_epidx);
                    if (ed_rd[COST_W-1:0] == r_cost) begin
                        n_status = ST_UNCHANGED;
                    end else begin
                        ed_we    = 1'b1;
                        n_status = ST_UPDATED;
                    end
                end else if (edge_miss) begin
                    done = 1'b1;
                    if (r_cnt != EDGES_MAX) begin
                        ed_we       = 1'b1;
                        cnt_we      = 1'b1;
                        n_status    = ST_ADDED;
                        n_node_slot = SLOT_W'(r_slot);
                    end
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= done;
            if (nm_we) begin
                r_used <= r_used + UW'(1);
            end
            case (r_state)
                S_IDLE:  r_pend <= 1'b0;
                S_NSCAN: r_pend <= node_issue || r_pend;
                S_ELOAD: r_pend <= 1'b0;
                S_ESCAN: r_pend <= edge_issue || r_pend;
                default: r_pend <= 1'b0;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_src  <= i_source_node;
            r_dst  <= i_dest_node;
            r_cost <= i_edge_cost;
            r_idx  <= '0;
        end
        if (r_state == S_NSCAN) begin
            if (node_issue) begin
                r_pidx <= r_idx[NW-1:0];
                r_idx  <= r_idx + UW'(1);
            end
            if (node_hit) begin
                r_slot <= r_pidx;
                r_base <= AW'(AW'(r_pidx) * EPN_A);
            end
        end
        if (r_state == S_ELOAD) begin
            r_cnt  <= cnt_rd;
            r_eidx <= '0;
        end
        if ((r_state == S_ESCAN) && edge_issue) begin
            r_epidx <= r_eidx;
            r_eidx  <= r_eidx + CW'(1);
        end
        if (done) begin
            r_status    <= n_status;
            r_node_slot <= n_node_slot;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_node_slot = r_node_slot;

    // Two results can never come back to back
    a_valid_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobes on consecutive cycles");

    // Slot count stays within the table
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NODE_LIMIT)
        else $error("slot count beyond table size");

    // An accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("beat taken but block not busy");

    // A created node bumps the slot count by one
    a_create_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_CREATED)) |-> (r_used == $past(r_used) + UW'(1)))
        else $error("node created without slot count step");

    // A dropped beat reports slot zero
    a_drop_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DROPPED)) |-> (o_node_slot == '0))
        else $error("dropped beat with non-zero slot");

endmodule
